FILE: sv/lane_line_slope_tracker_macros.svh
// ----------------------------------------------------------------------------
// Lane line slope tracker assertion macros
// Shorthand for the concurrent checks used in the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef LANE_LINE_SLOPE_TRACKER_MACROS_SVH
`define LANE_LINE_SLOPE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lst_pkg.sv
// ----------------------------------------------------------------------------
// Lane line slope tracker package
// Shared constants, register indexes and the queue control type.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int HISTORY_DEPTH_DEF = 30;
    localparam int COORD_BITS_DEF    = 12;

    localparam int SLOPE_BITS = 29;
    localparam int ICEPT_BITS = 34;
    localparam int FRAME_BITS = 12;
    localparam int THR_BITS   = 16;
    localparam int XOUT_BITS  = 16;

    localparam int OUT_FIELD_BITS = 4 * XOUT_BITS + 2 * FRAME_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS  = 2;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_ROWS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOPE_THR  = 1'd1;

    localparam logic [FRAME_BITS-1:0] FRAME_ROWS_RST = 12'd480;
    localparam logic [THR_BITS-1:0]   SLOPE_THR_RST  = 16'd13107;

    // y_top = floor(rows * 13 / 20) = floor(floor(rows * 13 / 4) / 5)
    localparam int Y_TOP_MUL = 13;
    localparam int RECIP5    = 52429;
    localparam int RECIP_SH  = 18;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic seg_ok;
        logic last;
    } t_qctl;

endpackage

FILE: sv/lst_ram.sv
// ----------------------------------------------------------------------------
// Lane line slope tracker RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/lst_div.sv
// ----------------------------------------------------------------------------
// Lane line slope tracker divider
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module lst_div #(
    parameter int NW = 48,
    parameter int DW = 34
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_acc;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;

    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] n_rem;

    always_comb begin
        num_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        trial   = {r_rem, r_acc[NW-1]};
        ge      = trial >= {1'b0, r_den};
        n_rem   = ge ? trial[DW-1:0] - r_den : trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_acc  <= num_mag;
                r_den  <= den_mag;
                r_rem  <= '0;
                r_neg  <= i_num[NW-1] ^ i_den[DW-1];
            end else if (r_busy) begin
                r_acc <= {r_acc[NW-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_acc) : $signed(r_acc);
endmodule

FILE: sv/lst_front.sv
// ----------------------------------------------------------------------------
// Lane line slope tracker front end
// Accepts segments, forms the deltas, flags usable ones and queues them.
// ----------------------------------------------------------------------------
module lst_front #(
    parameter int COORD_BITS = 12,
    parameter int IN_DATA_W  = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [IN_DATA_W-1:0]         i_s_tdata,
    input  logic                         i_s_tuser,
    input  logic                         i_s_tlast,
    output logic                         o_q_valid,
    output lst_pkg::t_qctl               o_q_ctl,
    output logic signed [COORD_BITS:0]   o_q_dx,
    output logic signed [COORD_BITS:0]   o_q_dy,
    output logic [COORD_BITS-1:0]        o_q_x1,
    output logic [COORD_BITS-1:0]        o_q_y1,
    input  logic                         i_q_pop
);
    import lst_pkg::*;

    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic                  accept;
    t_qctl                 ctl;

    t_qctl                      r_ctl [Q_DEPTH];
    logic signed [COORD_BITS:0] r_dx  [Q_DEPTH];
    logic signed [COORD_BITS:0] r_dy  [Q_DEPTH];
    logic [COORD_BITS-1:0]      r_x1  [Q_DEPTH];
    logic [COORD_BITS-1:0]      r_y1  [Q_DEPTH];
    logic [Q_AW-1:0]            r_wr, r_rd;
    logic [Q_AW:0]              r_cnt;

    always_comb begin
        x0 = i_s_tdata[0 +: COORD_BITS];
        y0 = i_s_tdata[COORD_BITS +: COORD_BITS];
        x1 = i_s_tdata[2*COORD_BITS +: COORD_BITS];
        y1 = i_s_tdata[3*COORD_BITS +: COORD_BITS];
        // Vertical and zero-length segments never reach the slope divider.
        ctl.seg_ok = i_s_tuser && (x0 != x1);
        ctl.last   = i_s_tlast;
    end

    assign o_s_tready = r_cnt != (Q_AW+1)'(Q_DEPTH);
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_ctl[r_wr] <= ctl;
                r_dx[r_wr]  <= $signed({1'b0, x0}) - $signed({1'b0, x1});
                r_dy[r_wr]  <= $signed({1'b0, y0}) - $signed({1'b0, y1});
                r_x1[r_wr]  <= x1;
                r_y1[r_wr]  <= y1;
                r_wr        <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(accept) - (Q_AW+1)'(i_q_pop);
        end
    end

    assign o_q_valid = r_cnt != '0;
    assign o_q_ctl   = r_ctl[r_rd];
    assign o_q_dx    = r_dx[r_rd];
    assign o_q_dy    = r_dy[r_rd];
    assign o_q_x1    = r_x1[r_rd];
    assign o_q_y1    = r_y1[r_rd];
endmodule

FILE: sv/lst_back.sv
// ----------------------------------------------------------------------------
// Lane line slope tracker back end
// Slope and intercept per segment, history rings, frame-end lane positions.
// ----------------------------------------------------------------------------
`include "lane_line_slope_tracker_macros.svh"

module lst_back #(
    parameter int HISTORY_DEPTH = 30,
    parameter int COORD_BITS    = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  lst_pkg::t_qctl                       i_q_ctl,
    input  logic signed [COORD_BITS:0]          i_q_dx,
    input  logic signed [COORD_BITS:0]          i_q_dy,
    input  logic [COORD_BITS-1:0]               i_q_x1,
    input  logic [COORD_BITS-1:0]               i_q_y1,
    output logic                                 o_q_pop,
    input  logic [lst_pkg::FRAME_BITS-1:0]       i_frame_rows,
    input  logic [lst_pkg::THR_BITS-1:0]         i_slope_thr,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [lst_pkg::OUT_DATA_BITS-1:0]    o_m_tdata,
    output logic [lst_pkg::OUT_USER_BITS-1:0]    o_m_tuser
);
    import lst_pkg::*;

    localparam int FW     = $clog2(HISTORY_DEPTH + 1);
    localparam int PW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int STOT_W = SLOPE_BITS + FW;
    localparam int ITOT_W = ICEPT_BITS + FW;
    localparam int NUM1_W = ITOT_W + 1;
    localparam int NW     = ITOT_W + 9;
    localparam int DW     = STOT_W;
    localparam int PRW    = SLOPE_BITS + COORD_BITS + 1;
    localparam int BQW    = PRW + 1;
    localparam int RW     = SLOPE_BITS + ICEPT_BITS;
    localparam int RAM_D  = 2 * (2 ** PW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WAIT   = 4'd1;
    localparam logic [3:0] S_SLOPE  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_ICEPT  = 4'd4;
    localparam logic [3:0] S_PUSH   = 4'd5;
    localparam logic [3:0] S_LAST   = 4'd6;
    localparam logic [3:0] S_SIDE   = 4'd7;
    localparam logic [3:0] S_AVB_GO = 4'd8;
    localparam logic [3:0] S_XT_GO  = 4'd9;
    localparam logic [3:0] S_XB_GO  = 4'd10;
    localparam logic [3:0] S_XDONE  = 4'd11;
    localparam logic [3:0] S_NEXT   = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    function automatic logic signed [SLOPE_BITS-1:0] f_sat_m(input logic signed [NW-1:0] v);
        if ((v[NW-1:SLOPE_BITS-1] == '0) || (v[NW-1:SLOPE_BITS-1] == '1)) begin
            return v[SLOPE_BITS-1:0];
        end
        return v[NW-1] ? {1'b1, {(SLOPE_BITS-1){1'b0}}} : {1'b0, {(SLOPE_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [ICEPT_BITS-1:0] f_sat_b(input logic signed [NW-1:0] v);
        if ((v[NW-1:ICEPT_BITS-1] == '0) || (v[NW-1:ICEPT_BITS-1] == '1)) begin
            return v[ICEPT_BITS-1:0];
        end
        return v[NW-1] ? {1'b1, {(ICEPT_BITS-1){1'b0}}} : {1'b0, {(ICEPT_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [XOUT_BITS-1:0] f_sat_x(input logic signed [NW-1:0] v);
        if ((v[NW-1:XOUT_BITS-1] == '0) || (v[NW-1:XOUT_BITS-1] == '1)) begin
            return v[XOUT_BITS-1:0];
        end
        return v[NW-1] ? {1'b1, {(XOUT_BITS-1){1'b0}}} : {1'b0, {(XOUT_BITS-1){1'b1}}};
    endfunction

    // ((y << 8) - avg_icept) << 8
    function automatic logic signed [NW-1:0] f_xnum(input logic [FRAME_BITS-1:0] y,
                                                   input logic signed [ITOT_W-1:0] ab);
        logic signed [NUM1_W-1:0] t;
        t = NUM1_W'($signed({1'b0, y, 8'd0})) - NUM1_W'(ab);
        return {t, 8'd0};
    endfunction

    logic [3:0]                   r_state, r_ret;
    t_qctl                        r_ctl;
    logic [COORD_BITS-1:0]        r_x1, r_y1;
    logic signed [SLOPE_BITS-1:0] r_m;
    logic signed [PRW-1:0]        r_prod;
    logic signed [ICEPT_BITS-1:0] r_b;
    logic                         r_side;
    logic [FW-1:0]                r_fill [2];
    logic [PW-1:0]                r_wp   [2];
    logic signed [STOT_W-1:0]     r_stot [2];
    logic signed [ITOT_W-1:0]     r_itot [2];
    logic signed [STOT_W-1:0]     r_am;
    logic signed [ITOT_W-1:0]     r_ab;
    logic signed [NW-1:0]         r_q;
    logic [1:0]                   r_lv;
    logic [XOUT_BITS-1:0]         r_xt [2];
    logic [XOUT_BITS-1:0]         r_xb [2];
    logic                         r_ov;
    logic [OUT_DATA_BITS-1:0]     r_odata;
    logic [OUT_USER_BITS-1:0]     r_ouser;

    logic                         div_start, div_done;
    logic signed [NW-1:0]         div_num, div_quo;
    logic signed [DW-1:0]         div_den;
    logic                         ram_we, ram_re;
    logic [PW:0]                  ram_waddr, ram_raddr;
    logic [RW-1:0]                ram_wdata, ram_rdata;

    logic signed [SLOPE_BITS-1:0] thr_m;
    logic                         push_r, push_l, n_side, full;
    logic signed [BQW-1:0]        bq, bq_adj;
    logic signed [ICEPT_BITS-1:0] b_val;
    logic [15:0]                  rows13;
    logic [30:0]                  yt_prod;
    logic [FRAME_BITS-1:0]        y_top;
    logic signed [SLOPE_BITS-1:0] old_m;
    logic signed [ICEPT_BITS-1:0] old_b;
    logic signed [DW-1:0]         fill_den;
    logic                         out_load;

    always_comb begin
        thr_m   = SLOPE_BITS'($signed({1'b0, i_slope_thr}));
        push_r  = r_m > thr_m;
        push_l  = r_m < -thr_m;
        n_side  = push_r;
        bq      = BQW'($signed({1'b0, r_y1, 16'd0})) - BQW'(r_prod);
        // Truncate toward zero on the division by 256.
        bq_adj  = bq + (bq[BQW-1] ? BQW'(255) : BQW'(0));
        b_val   = f_sat_b(NW'(bq_adj >>> 8));
        rows13  = 16'(i_frame_rows * 16'(Y_TOP_MUL));
        yt_prod = 31'(rows13[15:2]) * 31'(RECIP5);
        y_top   = yt_prod[RECIP_SH +: FRAME_BITS];
        full    = r_fill[r_side] == FW'(HISTORY_DEPTH);
        old_m   = ram_rdata[RW-1:ICEPT_BITS];
        old_b   = ram_rdata[ICEPT_BITS-1:0];
        fill_den = DW'($signed({1'b0, r_fill[r_side]}));
        out_load = (r_state == S_OUT) && (!r_ov || i_m_tready);

        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        ram_re    = 1'b0;
        ram_raddr = {n_side, r_wp[n_side]};
        ram_we    = (r_state == S_PUSH);
        ram_waddr = {r_side, r_wp[r_side]};
        ram_wdata = {r_m, r_b};

        case (r_state)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid && i_q_ctl.seg_ok) begin
                    div_start = 1'b1;
                    div_num   = NW'(i_q_dy) <<< 16;
                    div_den   = DW'(i_q_dx);
                end
            end
            S_ICEPT: begin
                ram_re = push_r || push_l;
            end
            S_SIDE: begin
                div_start = r_fill[r_side] != '0;
                div_num   = NW'(r_stot[r_side]);
                div_den   = fill_den;
            end
            S_AVB_GO: begin
                div_start = 1'b1;
                div_num   = NW'(r_itot[r_side]);
                div_den   = fill_den;
            end
            S_XT_GO: begin
                div_start = r_am != '0;
                div_num   = f_xnum(y_top, r_q[ITOT_W-1:0]);
                div_den   = r_am;
            end
            S_XB_GO: begin
                div_start = 1'b1;
                div_num   = f_xnum(i_frame_rows, r_ab);
                div_den   = r_am;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_side    <= 1'b0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
            r_wp[0]   <= '0;
            r_wp[1]   <= '0;
            r_stot[0] <= '0;
            r_stot[1] <= '0;
            r_itot[0] <= '0;
            r_itot[1] <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ctl <= i_q_ctl;
                        r_x1  <= i_q_x1;
                        r_y1  <= i_q_y1;
                        if (i_q_ctl.seg_ok) begin
                            r_ret   <= S_SLOPE;
                            r_state <= S_WAIT;
                        end else begin
                            r_state <= S_LAST;
                        end
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_q     <= div_quo;
                        r_state <= r_ret;
                    end
                end
                S_SLOPE: begin
                    r_m     <= f_sat_m(r_q);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PRW'(r_m) * PRW'($signed({1'b0, r_x1}));
                    r_state <= S_ICEPT;
                end
                S_ICEPT: begin
                    r_b    <= b_val;
                    r_side <= n_side;
                    r_state <= (push_r || push_l) ? S_PUSH : S_LAST;
                end
                S_PUSH: begin
                    // A full ring drops its oldest entry from the running sums.
                    r_stot[r_side] <= r_stot[r_side] + STOT_W'(r_m)
                                      - (full ? STOT_W'(old_m) : STOT_W'(0));
                    r_itot[r_side] <= r_itot[r_side] + ITOT_W'(r_b)
                                      - (full ? ITOT_W'(old_b) : ITOT_W'(0));
                    if (!full) begin
                        r_fill[r_side] <= r_fill[r_side] + 1'b1;
                    end
                    r_wp[r_side] <= (r_wp[r_side] == PW'(HISTORY_DEPTH - 1)) ?
                                    '0 : r_wp[r_side] + 1'b1;
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    r_side  <= 1'b0;
                    r_state <= r_ctl.last ? S_SIDE : S_IDLE;
                end
                S_SIDE: begin
                    if (r_fill[r_side] == '0) begin
                        r_lv[r_side] <= 1'b0;
                        r_xt[r_side] <= '0;
                        r_xb[r_side] <= '0;
                        r_state      <= S_NEXT;
                    end else begin
                        r_ret   <= S_AVB_GO;
                        r_state <= S_WAIT;
                    end
                end
                S_AVB_GO: begin
                    r_am    <= r_q[STOT_W-1:0];
                    r_ret   <= S_XT_GO;
                    r_state <= S_WAIT;
                end
                S_XT_GO: begin
                    r_ab         <= r_q[ITOT_W-1:0];
                    r_lv[r_side] <= 1'b1;
                    if (r_am == '0) begin
                        r_xt[r_side] <= '0;
                        r_xb[r_side] <= '0;
                        r_state      <= S_NEXT;
                    end else begin
                        r_ret   <= S_XB_GO;
                        r_state <= S_WAIT;
                    end
                end
                S_XB_GO: begin
                    r_xt[r_side] <= f_sat_x(r_q);
                    r_ret        <= S_XDONE;
                    r_state      <= S_WAIT;
                end
                S_XDONE: begin
                    r_xb[r_side] <= f_sat_x(r_q);
                    r_state      <= S_NEXT;
                end
                S_NEXT: begin
                    r_side  <= 1'b1;
                    r_state <= r_side ? S_OUT : S_SIDE;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_odata <= OUT_DATA_BITS'({i_frame_rows, y_top, r_xb[1], r_xt[1],
                                                   r_xb[0], r_xt[0]});
                        r_ouser <= r_lv;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    lst_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    lst_ram #(
        .WIDTH (RW),
        .DEPTH (RAM_D)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    `LST_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, 1'b1,
        (r_fill[0] <= FW'(HISTORY_DEPTH)) && (r_fill[1] <= FW'(HISTORY_DEPTH)),
        "history fill count above depth")
    `LST_ASSERT_IMP(a_wp_tracks_fill, i_clk, i_rst_n, r_fill[0] < FW'(HISTORY_DEPTH),
        FW'(r_wp[0]) == r_fill[0], "left write pointer out of step with fill")
    `LST_ASSERT_IMP(a_wp_tracks_fill_r, i_clk, i_rst_n, r_fill[1] < FW'(HISTORY_DEPTH),
        FW'(r_wp[1]) == r_fill[1], "right write pointer out of step with fill")
    `LST_ASSERT_NXT(a_div_wait, i_clk, i_rst_n, div_start, r_state == S_WAIT,
        "divider started without waiting for its quotient")
endmodule

FILE: sv/lane_line_slope_tracker.sv
// ----------------------------------------------------------------------------
// Lane line slope tracker
// Tracks left and right lane lines from line segments and reports lane x.
// ----------------------------------------------------------------------------
// Segments enter on the s_axis channel: tdata holds x_start, y_start, x_end,
// y_end, tuser marks that a segment is present and tlast ends the frame.
// In the back end each usable segment passes through the serial divider
// forming the slope, then the intercept multiply and the history ring
// update. A frame end adds up to eight more divisions (averages and lane x
// per side) before its result appears on the m_axis channel. Only frame
// ends give results.
// A four-entry queue takes segments while the back end is busy; s_axis_tready
// falls only when the queue is full. A result waits in the output register
// while m_axis_tready is low; the back end then holds and the queue fills.
// Reset empties both histories and the queue and sets frame_rows to 480 and
// slope_threshold to 0.2. Configuration writes (index 0 frame_rows, index 1
// slope_threshold) take effect at once and belong between frames.
// ----------------------------------------------------------------------------
module lane_line_slope_tracker #(
    parameter int HISTORY_DEPTH = lst_pkg::HISTORY_DEPTH_DEF,
    parameter int COORD_BITS    = lst_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lst_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [lst_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // x_start, y_start, x_end, y_end
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    // segment_present
    input  logic                                 i_s_axis_tuser,
    input  logic                                 i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // left_x_top, left_x_bottom, right_x_top, right_x_bottom, y_top, y_bottom
    output logic [lst_pkg::OUT_DATA_BITS-1:0]    o_m_axis_tdata,
    // left_valid, right_valid
    output logic [lst_pkg::OUT_USER_BITS-1:0]    o_m_axis_tuser
);
    import lst_pkg::*;

    localparam int IN_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;

    logic [FRAME_BITS-1:0] r_frame_rows;
    logic [THR_BITS-1:0]   r_slope_thr;

    logic                       q_valid, q_pop;
    t_qctl                      q_ctl;
    logic signed [COORD_BITS:0] q_dx, q_dy;
    logic [COORD_BITS-1:0]      q_x1, q_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= FRAME_ROWS_RST;
            r_slope_thr  <= SLOPE_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_ROWS: r_frame_rows <= i_cfg_wdata[FRAME_BITS-1:0];
                REG_SLOPE_THR:  r_slope_thr  <= i_cfg_wdata[THR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    lst_front #(
        .COORD_BITS (COORD_BITS),
        .IN_DATA_W  (IN_DATA_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_s_tlast  (i_s_axis_tlast),
        .o_q_valid  (q_valid),
        .o_q_ctl    (q_ctl),
        .o_q_dx     (q_dx),
        .o_q_dy     (q_dy),
        .o_q_x1     (q_x1),
        .o_q_y1     (q_y1),
        .i_q_pop    (q_pop)
    );

    lst_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COORD_BITS    (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_ctl      (q_ctl),
        .i_q_dx       (q_dx),
        .i_q_dy       (q_dy),
        .i_q_x1       (q_x1),
        .i_q_y1       (q_y1),
        .o_q_pop      (q_pop),
        .i_frame_rows (r_frame_rows),
        .i_slope_thr  (r_slope_thr),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tdata    (o_m_axis_tdata),
        .o_m_tuser    (o_m_axis_tuser)
    );
endmodule

FILE: tb/tb_lane_line_slope_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane line slope tracker testbench
// Sends line segments and frame ends through the input stream and checks each
// frame result on the output stream against a fixed-point lane predictor. The
// run covers a directed table, then random frames under several settings.
// ----------------------------------------------------------------------------
module tb_lane_line_slope_tracker;
    import lst_pkg::*;

    localparam int  DEPTH      = 30;
    localparam int  SETTLE     = 1000;
    localparam int  LIMIT      = 1500000;
    localparam int  N_DIRECTED = 14;
    localparam int  N_PHASES   = 6;

    typedef struct packed {
        logic               lv;
        logic               rv;
        logic signed [15:0] lxt;
        logic signed [15:0] lxb;
        logic signed [15:0] rxt;
        logic signed [15:0] rxb;
        logic [11:0]        yt;
        logic [11:0]        yb;
    } t_lane_result;

    typedef struct packed {
        bit           pres;
        bit [11:0]    xs;
        bit [11:0]    ys;
        bit [11:0]    xe;
        bit [11:0]    ye;
        bit           last;
        bit           typed;
        t_lane_result res;
    } t_seg_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // x_start, y_start, x_end, y_end
    logic        i_s_axis_tuser = 1'b0; // segment_present
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // left_x_top, left_x_bottom, right_x_top, right_x_bottom, y_top, y_bottom
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic [OUT_USER_BITS-1:0] o_m_axis_tuser; // left_valid, right_valid

    lane_line_slope_tracker dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Lane history of the predictor; side 0 is left, side 1 is right.
    longint       slope_hist [2][DEPTH];
    longint       icept_hist [2][DEPTH];
    int           hist_fill  [2];
    int           hist_wp    [2];
    longint       slope_sum  [2];
    longint       icept_sum  [2];
    int           rows_reg;
    int           thr_reg;
    t_lane_result pending_frames [$];
    int           errors;
    int           cycles;
    bit           calm;
    bit           long_hold_req;
    int           stall_left;

    function automatic longint clamp(longint v, int bits);
        longint hi = (longint'(1) <<< (bits - 1)) - 1;
        longint lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic [15:0] lane_x(longint am, longint ab, int y);
        longint num;
        if (am == 0) return '0;
        num = longint'(y) * 256 - ab;
        return 16'(clamp((num * 256) / am, 16));
    endfunction

    task automatic apply_segment(input bit pres, input bit [11:0] xs, ys, xe, ye);
        longint dx, dy, m, b;
        int     s, p;
        if (!pres) return;
        dx = longint'(xs) - longint'(xe);
        dy = longint'(ys) - longint'(ye);
        if (dx == 0) return;
        m = clamp((dy * 65536) / dx, SLOPE_BITS);
        b = clamp((longint'(ye) * 65536 - m * longint'(xe)) / 256, ICEPT_BITS);
        if (m > thr_reg) s = 1;
        else if (m < -thr_reg) s = 0;
        else return;
        p = hist_wp[s];
        if (hist_fill[s] >= DEPTH) begin
            // The oldest entry is overwritten and leaves the running sums.
            slope_sum[s] -= slope_hist[s][p];
            icept_sum[s] -= icept_hist[s][p];
        end else begin
            hist_fill[s]++;
        end
        slope_hist[s][p] = m;
        icept_hist[s][p] = b;
        slope_sum[s] += m;
        icept_sum[s] += b;
        hist_wp[s] = (p + 1 >= DEPTH) ? 0 : p + 1;
    endtask

    function automatic t_lane_result frame_outcome();
        t_lane_result r;
        longint       am, ab;
        logic [15:0]  xt [2];
        logic [15:0]  xb [2];
        r = '0;
        r.yb = rows_reg[11:0];
        r.yt = 12'((rows_reg * 13) / 20);
        for (int s = 0; s < 2; s++) begin
            xt[s] = '0;
            xb[s] = '0;
            if (hist_fill[s] != 0) begin
                am = slope_sum[s] / hist_fill[s];
                ab = icept_sum[s] / hist_fill[s];
                xt[s] = lane_x(am, ab, r.yt);
                xb[s] = lane_x(am, ab, r.yb);
            end
        end
        r.lv  = hist_fill[0] != 0;
        r.rv  = hist_fill[1] != 0;
        r.lxt = xt[0];
        r.lxb = xb[0];
        r.rxt = xt[1];
        r.rxb = xb[1];
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic check_frame();
        t_lane_result want, got;
        if (pending_frames.size() == 0) begin
            report("unexpected result", 1, 0);
            return;
        end
        want = pending_frames.pop_front();
        got.lv  = o_m_axis_tuser[0];
        got.rv  = o_m_axis_tuser[1];
        got.lxt = o_m_axis_tdata[15:0];
        got.lxb = o_m_axis_tdata[31:16];
        got.rxt = o_m_axis_tdata[47:32];
        got.rxb = o_m_axis_tdata[63:48];
        got.yt  = o_m_axis_tdata[75:64];
        got.yb  = o_m_axis_tdata[87:76];
        if (got.lv != want.lv)   report("left_valid", got.lv, want.lv);
        if (got.rv != want.rv)   report("right_valid", got.rv, want.rv);
        if (got.lxt !== want.lxt) report("left_x_top", got.lxt, want.lxt);
        if (got.lxb !== want.lxb) report("left_x_bottom", got.lxb, want.lxb);
        if (got.rxt !== want.rxt) report("right_x_top", got.rxt, want.rxt);
        if (got.rxb !== want.rxb) report("right_x_bottom", got.rxb, want.rxb);
        if (got.yt !== want.yt)   report("y_top", got.yt, want.yt);
        if (got.yb !== want.yb)   report("y_bottom", got.yb, want.yb);
    endtask

    // Result side: checks each accepted result and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_frame();
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (long_hold_req) begin
                // A long hold-off lets the input queue fill and stall the sender.
                long_hold_req = 1'b0;
                stall_left = 3000;
                i_m_axis_tready <= 1'b0;
            end else if (calm || $urandom_range(0, 99) < 70) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                          : $urandom_range(20, 200);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_lane_line_slope_tracker NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    task automatic send_request(input bit pres, input bit [11:0] xs, ys, xe, ye,
                                input bit last, input bit typed, input t_lane_result res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ye, xe, ys, xs};
        i_s_axis_tuser  <= pres;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_segment(pres, xs, ys, xe, ye);
        if (last) pending_frames.insert(pending_frames.size(), typed ? res : frame_outcome());
    endtask

    task automatic send_random(input bit force_last);
        bit [11:0] xs, ys, xe, ye;
        bit        pres;
        int        r;
        xs = 12'($urandom);
        ys = 12'($urandom);
        xe = 12'($urandom);
        ye = 12'($urandom);
        pres = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            if (xs == xe) xe = xs ^ 12'd1;
        end else if (r < 80) begin
            xe = xs;
        end else if (r < 84) begin
            xe = xs;
            ye = ys;
        end else if (r < 90) begin
            ye = ys ^ 12'($urandom_range(0, 1));
        end else begin
            pres = 1'b0;
        end
        send_request(pres, xs, ys, xe, ye, force_last || $urandom_range(0, 7) == 0,
                     1'b0, '0);
    endtask

    // Waits until every frame result is back, then lets queued segments finish.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        if (idx == REG_FRAME_ROWS) begin
            i_cfg_wdata <= {4'($urandom), 12'(val)};
            rows_reg = val & 12'hFFF;
        end else begin
            i_cfg_wdata <= 16'(val);
            thr_reg = val & 16'hFFFF;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Empty frames read zeros; slope +1 through the origin gives x = y, and
    // slope -1 through (4095, 0) gives x = 4095 - y.
    t_seg_row dir_rows [N_DIRECTED] = '{
        '{0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1, 1,
          '{0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd312, 12'd480}},
        '{1, 12'd100, 12'd0, 12'd100, 12'd4095, 0, 0, '0},
        '{1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 0, 0, '0},
        '{1, 12'd0, 12'd7, 12'd4095, 12'd7, 0, 0, '0},
        '{1, 12'd0, 12'd0, 12'd5, 12'd1, 0, 0, '0},
        '{1, 12'd0, 12'd1, 12'd5, 12'd0, 0, 0, '0},
        '{0, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 0, 0, '0},
        '{1, 12'd0, 12'd0, 12'd4095, 12'd1, 1, 1,
          '{0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd312, 12'd480}},
        '{1, 12'd0, 12'd0, 12'd4095, 12'd4095, 1, 1,
          '{0, 1, 16'sd0, 16'sd0, 16'sd312, 16'sd480, 12'd312, 12'd480}},
        '{1, 12'd0, 12'd4095, 12'd4095, 12'd0, 1, 1,
          '{1, 1, 16'sd3783, 16'sd3615, 16'sd312, 16'sd480, 12'd312, 12'd480}},
        '{1, 12'd0, 12'd0, 12'd1, 12'd4095, 0, 0, '0},
        '{1, 12'd4095, 12'd0, 12'd4094, 12'd4095, 1, 0, '0},
        '{1, 12'd1, 12'd2, 12'd4095, 12'd4094, 0, 0, '0},
        '{0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1, 0, '0}
    };

    int phase_rows [N_PHASES];
    int phase_thr  [N_PHASES];

    initial begin
        for (int s = 0; s < 2; s++) begin
            hist_fill[s] = 0;
            hist_wp[s]   = 0;
            slope_sum[s] = 0;
            icept_sum[s] = 0;
        end
        rows_reg = 480;
        thr_reg  = 13107;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        long_hold_req = 1'b0;
        stall_left = 0;
        phase_rows = '{4095, 1, 720, $urandom_range(1, 4095), $urandom_range(1, 4095), 480};
        phase_thr  = '{65535, 0, 6554, $urandom_range(0, 65535), $urandom_range(0, 3000),
                       13107};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(dir_rows[i].pres, dir_rows[i].xs, dir_rows[i].ys,
                         dir_rows[i].xe, dir_rows[i].ye, dir_rows[i].last,
                         dir_rows[i].typed, dir_rows[i].res);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            cfg_write(REG_FRAME_ROWS, phase_rows[ph]);
            cfg_write(REG_SLOPE_THR, phase_thr[ph]);
            calm = (ph == 2);
            if (ph == 1) long_hold_req = 1'b1;
            for (int n = 0; n < 90; n++) send_random(n == 89);
        end
        drain();

        if (errors == 0) begin
            $display("tb_lane_line_slope_tracker OK");
        end else begin
            $display("tb_lane_line_slope_tracker NOT OK");
        end
        $finish;
    end

endmodule
